/* rtl/lktm_pkg.sv */
// ----------------------------------------------------------------------------
// lktm_pkg: shared types and constants of the lane-keep turn-mode controller
// Field widths, register indexes, sequencer states, the control/status
// structs between sequencer and datapath, and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package lktm_pkg;

   localparam int SLOPE_W     = 16;
   localparam int CPOS_W      = 12;
   localparam int THR_W       = 16;
   localparam int BAND_W      = 15;
   localparam int TICK_W      = 8;
   localparam int STEER_W     = 16;
   localparam int TSTEER_W    = 15;
   localparam int GAIN_W      = 24;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int SUM_W       = SLOPE_W + 1;
   localparam int ERR_W       = CPOS_W + 2;
   localparam int PROD_W      = GAIN_W + ERR_W - 1;
   localparam int CORDIC_W    = 32;
   localparam int ANGLE_W     = 27;
   localparam int ITERS       = 24;
   localparam int ITER_W      = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_THROTTLE   = 8'd0,
      CSR_MIN_THROTTLE    = 8'd1,
      CSR_TURN_LOW_SLOPE  = 8'd2,
      CSR_TURN_HIGH_SLOPE = 8'd3,
      CSR_ENTRY_TICKS     = 8'd4,
      CSR_EXIT_TICKS      = 8'd5,
      CSR_TURN_STEER      = 8'd6,
      CSR_CENTER_GAIN     = 8'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CORDIC,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STEER_FIXED,
      STEER_ATAN,
      STEER_CENTER
   } steer_kind_type;

   typedef struct packed {
      logic              capture;
      logic              eval;
      logic              cordic_step;
      logic [ITER_W-1:0] iter;
      logic              publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_cordic;
   } dp_status_type;

   // atan(2^-i) in Q.24, rounded to nearest.
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
      logic signed [ANGLE_W-1:0] v;
      case (i)
         5'd0:    v = 27'sd13176795;
         5'd1:    v = 27'sd7778716;
         5'd2:    v = 27'sd4110060;
         5'd3:    v = 27'sd2086331;
         5'd4:    v = 27'sd1047214;
         5'd5:    v = 27'sd524117;
         5'd6:    v = 27'sd262123;
         5'd7:    v = 27'sd131069;
         5'd8:    v = 27'sd65536;
         5'd9:    v = 27'sd32768;
         5'd10:   v = 27'sd16384;
         5'd11:   v = 27'sd8192;
         5'd12:   v = 27'sd4096;
         5'd13:   v = 27'sd2048;
         5'd14:   v = 27'sd1024;
         5'd15:   v = 27'sd512;
         5'd16:   v = 27'sd256;
         5'd17:   v = 27'sd128;
         5'd18:   v = 27'sd64;
         5'd19:   v = 27'sd32;
         5'd20:   v = 27'sd16;
         5'd21:   v = 27'sd8;
         5'd22:   v = 27'sd4;
         5'd23:   v = 27'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/lktm_if.sv */
// ----------------------------------------------------------------------------
// lktm_if: valid/ready channel interfaces of the turn-mode controller
// Request (one control tick), response (one command) and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface lktm_req_if;
   import lktm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      left_valid;
   logic                      right_valid;
   logic                      center_valid;
   logic signed [SLOPE_W-1:0] slope_left;
   logic signed [SLOPE_W-1:0] slope_right;
   logic [CPOS_W-1:0]         center_pos;

   modport source(output valid, left_valid, right_valid, center_valid,
                  slope_left, slope_right, center_pos, input ready);
   modport sink(input valid, left_valid, right_valid, center_valid,
                slope_left, slope_right, center_pos, output ready);
endinterface

interface lktm_rsp_if;
   import lktm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [STEER_W-1:0] steer;
   logic [THR_W-1:0]          throttle;
   logic                      turning;

   modport source(output valid, steer, throttle, turning, input ready);
   modport sink(input valid, steer, throttle, turning, output ready);
endinterface

interface lktm_csr_if;
   import lktm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/lane_keep_turn_mode_controller.sv */
// ----------------------------------------------------------------------------
// lane_keep_turn_mode_controller: lane-keeping steer/throttle with turn mode
// One control tick in, one steer/throttle command out, with turn-mode
// entry and exit hysteresis and a CORDIC arctangent for single-side steer.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake      Carries
// req_if   in   valid/ready    slope and center flags and values of one tick
// rsp_if   out  valid/ready    steer (Q2.14), throttle (Q0.16), turning
// csr_if   in   valid/ready    register index and write data, never stalls
//
// A response is registered once its item has passed the evaluation and done
// states, with the CORDIC pass between them when one slope alone steers the
// car: the CORDIC unit resolves one of 24 arctangent steps per cycle. A new
// item can be accepted in the cycle after the previous one leaves the datapath,
// even while its response still waits in the output register. A synchronous
// reset restores register defaults and clears the turn-mode state; a stalled
// response holds its payload, and a second finished item then stalls input.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_keep_turn_mode_controller #(
   parameter int FRAME_COLS = 800
) (
   input  logic              clock,
   input  logic              reset,
   lktm_req_if.sink          req_if,
   lktm_rsp_if.source        rsp_if,
   lktm_csr_if.sink          csr_if
);
   import lktm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Register writes complete in the cycle they are offered. The user must issue
   // them only while the block is idle (not enforced), so no tick sees a half-written set.
   assign csr_if.ready = 1'b1;

   // The sequencer accepts a tick only from idle, then walks the datapath
   // through evaluation, the optional CORDIC pass and the response load.
   lktm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath owns every register that carries numbers: configuration,
   // mode counters, the captured tick, the CORDIC unit and the response.
   lktm_datapath #(
      .FRAME_COLS (FRAME_COLS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_if.valid),
      .csr_index    (csr_if.index),
      .csr_data     (csr_if.data),
      .left_valid   (req_if.left_valid),
      .right_valid  (req_if.right_valid),
      .center_valid (req_if.center_valid),
      .slope_left   (req_if.slope_left),
      .slope_right  (req_if.slope_right),
      .center_pos   (req_if.center_pos),
      .steer        (rsp_if.steer),
      .throttle     (rsp_if.throttle),
      .turning      (rsp_if.turning)
   );

endmodule

`default_nettype wire

/* rtl/lktm_datapath.sv */
// ----------------------------------------------------------------------------
// lktm_datapath: registers and arithmetic of the turn-mode controller
// Holds the configuration, the mode state, the captured tick, the CORDIC
// vectoring unit, the center-gain product and the response payload.
// ----------------------------------------------------------------------------
`default_nettype none

module lktm_datapath #(
   parameter int FRAME_COLS = 800
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  lktm_pkg::ctrl_cmd_type                     cmd,
   output lktm_pkg::dp_status_type                    status,
   input  logic                                       csr_we,
   input  logic [lktm_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [lktm_pkg::CSR_DATA_W-1:0]            csr_data,
   input  logic                                       left_valid,
   input  logic                                       right_valid,
   input  logic                                       center_valid,
   input  logic signed [lktm_pkg::SLOPE_W-1:0]        slope_left,
   input  logic signed [lktm_pkg::SLOPE_W-1:0]        slope_right,
   input  logic [lktm_pkg::CPOS_W-1:0]                center_pos,
   output logic signed [lktm_pkg::STEER_W-1:0]        steer,
   output logic [lktm_pkg::THR_W-1:0]                 throttle,
   output logic                                       turning
);
   import lktm_pkg::*;

   function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
      return (v == {TICK_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Configuration registers.
   logic [THR_W-1:0]    base_throttle_ff, min_throttle_ff;
   logic [BAND_W-1:0]   turn_low_ff, turn_high_ff;
   logic [TICK_W-1:0]   entry_ticks_ff, exit_ticks_ff;
   logic [TSTEER_W-1:0] turn_steer_ff;
   logic [GAIN_W-1:0]   center_gain_ff;

   // Mode state.
   logic                turn_mode_ff, turn_mode_in;
   logic                turn_left_ff, turn_left_in;
   logic [TICK_W-1:0]   entry_count_ff, entry_count_in;
   logic [TICK_W-1:0]   exit_count_ff, exit_count_in;

   // Captured tick.
   logic                lv_ff, rv_ff, cv_ff;
   logic signed [SLOPE_W-1:0] ls_ff, rs_ff;
   logic [CPOS_W-1:0]   cpos_ff;

   // Working results of one tick.
   steer_kind_type             kind_ff, kind_in;
   logic signed [STEER_W-1:0]  steer_w_ff, steer_w_in;
   logic [THR_W-1:0]           throttle_w_ff, throttle_w_in;
   logic                       err_neg_ff;
   logic [PROD_W-1:0]          product_ff, product_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;

   // Response payload.
   logic signed [STEER_W-1:0]  steer_ff, steer_in;
   logic [THR_W-1:0]           throttle_ff;
   logic                       turning_ff;

   // Tick evaluation signals.
   logic signed [SUM_W-1:0]    s2;
   logic [SUM_W-1:0]           mag;
   logic                       any_side, in_band, s2_pos;
   logic                       tm1, tl1;
   logic [TICK_W-1:0]          ec1, xc1;
   logic [THR_W-1:0]           half_thr, turn_thr;
   logic signed [SLOPE_W-1:0]  one_slope;
   logic signed [ERR_W-1:0]    err2;
   logic [ERR_W-2:0]           err_mag;

   // CORDIC step signals.
   logic signed [CORDIC_W-1:0] dx, dy;
   logic signed [ANGLE_W-1:0]  angle;
   logic                       y_pos;

   // Final steer signals.
   logic [ANGLE_W-1:0]         z_mag, z_rnd;
   logic [STEER_W-1:0]         atan_mag;
   logic [PROD_W-1:0]          p_rnd;
   logic [PROD_W-12:0]         p_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_throttle_ff <= 16'd19661;
         min_throttle_ff  <= 16'd3277;
         turn_low_ff      <= 15'd410;
         turn_high_ff     <= 15'd1556;
         entry_ticks_ff   <= 8'd5;
         exit_ticks_ff    <= 8'd5;
         turn_steer_ff    <= 15'd16384;
         center_gain_ff   <= 24'd41943;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_THROTTLE:   base_throttle_ff <= csr_data[THR_W-1:0];
            CSR_MIN_THROTTLE:    min_throttle_ff  <= csr_data[THR_W-1:0];
            CSR_TURN_LOW_SLOPE:  turn_low_ff      <= csr_data[BAND_W-1:0];
            CSR_TURN_HIGH_SLOPE: turn_high_ff     <= csr_data[BAND_W-1:0];
            CSR_ENTRY_TICKS:     entry_ticks_ff   <= csr_data[TICK_W-1:0];
            CSR_EXIT_TICKS:      exit_ticks_ff    <= csr_data[TICK_W-1:0];
            CSR_TURN_STEER:      turn_steer_ff    <= csr_data[TSTEER_W-1:0];
            CSR_CENTER_GAIN:     center_gain_ff   <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lv_ff   <= left_valid;
         rv_ff   <= right_valid;
         cv_ff   <= center_valid;
         ls_ff   <= slope_left;
         rs_ff   <= slope_right;
         cpos_ff <= center_pos;
      end
   end

   // The tick slope is kept doubled so the mean of both sides stays exact.
   always_comb begin
      if (lv_ff && rv_ff) begin
         s2 = {ls_ff[SLOPE_W-1], ls_ff} + {rs_ff[SLOPE_W-1], rs_ff};
      end else if (lv_ff) begin
         s2 = {ls_ff, 1'b0};
      end else if (rv_ff) begin
         s2 = {rs_ff, 1'b0};
      end else begin
         s2 = '0;
      end
      mag      = s2[SUM_W-1] ? SUM_W'(-s2) : SUM_W'(s2);
      any_side = lv_ff || rv_ff;
      in_band  = (mag >= {1'b0, turn_low_ff, 1'b0}) && (mag <= {1'b0, turn_high_ff, 1'b0});
      s2_pos   = !s2[SUM_W-1] && (s2 != '0);
   end

   // Entry is checked first; a tick that enters turn mode is then checked for exit.
   always_comb begin
      ec1 = entry_count_ff;
      xc1 = exit_count_ff;
      tm1 = turn_mode_ff;
      tl1 = turn_left_ff;
      if (!turn_mode_ff) begin
         ec1 = (any_side && in_band) ? sat_inc(entry_count_ff) : '0;
         if (ec1 >= entry_ticks_ff) begin
            tm1 = 1'b1;
            xc1 = '0;
            tl1 = !s2_pos;
         end
      end
      turn_mode_in   = tm1;
      turn_left_in   = tl1;
      entry_count_in = ec1;
      exit_count_in  = xc1;
      if (tm1) begin
         exit_count_in = (any_side && !in_band) ? sat_inc(xc1) : '0;
         if (exit_count_in >= exit_ticks_ff) begin
            turn_mode_in   = 1'b0;
            entry_count_in = '0;
         end
      end
   end

   always_comb begin
      half_thr      = base_throttle_ff >> 1;
      turn_thr      = (half_thr > min_throttle_ff) ? half_thr : min_throttle_ff;
      throttle_w_in = tm1 ? turn_thr : base_throttle_ff;
      steer_w_in    = '0;
      if (tm1) begin
         kind_in    = STEER_FIXED;
         steer_w_in = tl1 ? {1'b0, turn_steer_ff} : -{1'b0, turn_steer_ff};
      end else if (lv_ff != rv_ff) begin
         kind_in = STEER_ATAN;
      end else if (lv_ff && rv_ff && cv_ff) begin
         kind_in = STEER_CENTER;
      end else begin
         kind_in = STEER_FIXED;
      end
      one_slope  = lv_ff ? ls_ff : rs_ff;
      err2       = {1'b0, cpos_ff, 1'b0} - ERR_W'(FRAME_COLS);
      err_mag    = err2[ERR_W-1] ? (ERR_W-1)'(-err2) : err2[ERR_W-2:0];
      product_in = PROD_W'(center_gain_ff) * PROD_W'(err_mag);
   end

   assign status.need_cordic = (kind_in == STEER_ATAN);

   // One CORDIC vectoring step per cycle; >>> gives the floor shift.
   always_comb begin
      dx    = y_ff >>> cmd.iter;
      dy    = x_ff >>> cmd.iter;
      angle = atan_entry(cmd.iter);
      y_pos = !y_ff[CORDIC_W-1] && (y_ff != '0);
      x_in  = x_ff;
      y_in  = y_ff;
      z_in  = z_ff;
      if (cmd.eval) begin
         x_in = CORDIC_W'(1) <<< 24;
         y_in = {{(CORDIC_W-SLOPE_W-12){one_slope[SLOPE_W-1]}}, one_slope, 12'b0};
         z_in = '0;
      end else if (cmd.cordic_step) begin
         if (y_pos) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + angle;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.eval) begin
         kind_ff       <= kind_in;
         steer_w_ff    <= steer_w_in;
         throttle_w_ff <= throttle_w_in;
         err_neg_ff    <= err2[ERR_W-1];
         product_ff    <= product_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_mode_ff   <= 1'b0;
         turn_left_ff   <= 1'b0;
         entry_count_ff <= '0;
         exit_count_ff  <= '0;
      end else if (cmd.eval) begin
         turn_mode_ff   <= turn_mode_in;
         turn_left_ff   <= turn_left_in;
         entry_count_ff <= entry_count_in;
         exit_count_ff  <= exit_count_in;
      end
   end

   // The angle is negated; the gain term takes the opposite sign of the error.
   always_comb begin
      z_mag    = z_ff[ANGLE_W-1] ? ANGLE_W'(-z_ff) : ANGLE_W'(z_ff);
      z_rnd    = z_mag + ANGLE_W'(512);
      atan_mag = z_rnd[STEER_W+9:10];
      p_rnd    = product_ff + PROD_W'(1024);
      p_mag    = p_rnd[PROD_W-1:11];
      case (kind_ff)
         STEER_ATAN: begin
            steer_in = z_ff[ANGLE_W-1] ? atan_mag : -atan_mag;
         end
         STEER_CENTER: begin
            if (err_neg_ff) begin
               steer_in = (p_mag > (PROD_W-11)'(32767)) ? 16'sh7FFF : p_mag[STEER_W-1:0];
            end else begin
               steer_in = (p_mag > (PROD_W-11)'(32768)) ? 16'sh8000 : -p_mag[STEER_W-1:0];
            end
         end
         default: begin
            steer_in = steer_w_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         steer_ff    <= steer_in;
         throttle_ff <= throttle_w_ff;
         turning_ff  <= turn_mode_ff;
      end
   end

   assign steer    = steer_ff;
   assign throttle = throttle_ff;
   assign turning  = turning_ff;

endmodule

`default_nettype wire

/* rtl/lktm_ctrl.sv */
// ----------------------------------------------------------------------------
// lktm_ctrl: sequencer of the turn-mode controller
// Takes one tick at a time, steps the CORDIC unit and owns the response
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lktm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lktm_pkg::ctrl_cmd_type  cmd,
   input  lktm_pkg::dp_status_type status
);
   import lktm_pkg::*;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_EVAL;
         ST_EVAL:   state_in = status.need_cordic ? ST_CORDIC : ST_DONE;
         ST_CORDIC: if (iter_ff == ITER_W'(ITERS - 1)) state_in = ST_DONE;
         ST_DONE:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd.capture     = 1'b0;
      cmd.eval        = 1'b0;
      cmd.cordic_step = 1'b0;
      cmd.publish     = 1'b0;
      cmd.iter        = iter_ff;
      iter_in         = iter_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            iter_in  = '0;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
         end
         ST_DONE: begin
            cmd.publish = slot_free;
         end
         default: ;
      endcase
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/lktm_checker.sv */
// ----------------------------------------------------------------------------
// lktm_checker: port-level checks of the turn-mode controller
// Watches the channels of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module lktm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lktm_pkg::STEER_W-1:0] rsp_steer,
   input logic [lktm_pkg::THR_W-1:0]          rsp_throttle,
   input logic                                rsp_turning,
   input logic                                csr_ready
);
   import lktm_pkg::*;

   // A stalled response keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_steer) &&
      $stable(rsp_throttle) && $stable(rsp_turning))
      else $error("response changed while stalled");

   // Ticks are handled one at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a tick is in work");

   // Evaluation lies between acceptance and any response of the tick.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response raised directly after acceptance");

   // Reset leaves the block idle and ready, and register writes never stall.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && csr_ready)
      else $error("block not idle after reset");

endmodule

bind lane_keep_turn_mode_controller lktm_checker u_lktm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_steer    (rsp_if.steer),
   .rsp_throttle (rsp_if.throttle),
   .rsp_turning  (rsp_if.turning),
   .csr_ready    (csr_if.ready)
);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the lane-keep turn-mode controller
// Drives control ticks through the request channel under random pacing on
// both sides, predicts every steer/throttle command from its own model of the
// turn-mode hysteresis, arctangent and center steering, and compares each
// command field by field. The registers are rewritten between phases,
// extreme settings included.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lktm_pkg::*;

   localparam int          FRAME_COLS     = 800;
   localparam int unsigned NUM_REGS       = CSR_CENTER_GAIN + 1;
   localparam int          SLOPE_MAX      = 32767;
   localparam int unsigned BACKLOG_CYCLES = 400;
   localparam int unsigned IDLE_LIMIT     = 5000;

   // One control tick as it crosses the request channel.
   typedef struct {
      logic                      left_valid;
      logic                      right_valid;
      logic                      center_valid;
      logic signed [SLOPE_W-1:0] slope_left;
      logic signed [SLOPE_W-1:0] slope_right;
      logic [CPOS_W-1:0]         center_pos;
   } tick_type;

   // One steer/throttle command as it leaves the block.
   typedef struct {
      logic signed [STEER_W-1:0] steer;
      logic [THR_W-1:0]          throttle;
      logic                      turning;
   } command_type;

   // Kinds of tick runs used to shape the random stimulus.
   typedef enum {
      SEG_IN_BAND,
      SEG_OUT_BAND,
      SEG_NO_SLOPE,
      SEG_NOISE
   } seg_kind_type;

   // Keeps a private copy of the registers and of the turn-mode state, works
   // out the command of each accepted tick and holds it until it comes back.
   class steer_book_type;
      command_type       pending_cmds[$];
      int unsigned       mismatches;
      longint            angle_q24[ITERS];
      logic [THR_W-1:0]  base_thr;
      logic [THR_W-1:0]  min_thr;
      logic [BAND_W-1:0] band_low;
      logic [BAND_W-1:0] band_high;
      logic [TICK_W-1:0] enter_need;
      logic [TICK_W-1:0] leave_need;
      logic [BAND_W-1:0] turn_mag;
      logic [GAIN_W-1:0] gain;
      logic              turn_mode;
      logic              turn_left;
      logic [TICK_W-1:0] entry_count;
      logic [TICK_W-1:0] exit_count;

      function new();
         angle_q24 = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                       262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                       1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
         base_thr    = 16'd19661;
         min_thr     = 16'd3277;
         band_low    = 15'd410;
         band_high   = 15'd1556;
         enter_need  = 8'd5;
         leave_need  = 8'd5;
         turn_mag    = 15'd16384;
         gain        = 24'd41943;
         turn_mode   = 1'b0;
         turn_left   = 1'b0;
         entry_count = '0;
         exit_count  = '0;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BASE_THROTTLE:   base_thr   = data[THR_W-1:0];
            CSR_MIN_THROTTLE:    min_thr    = data[THR_W-1:0];
            CSR_TURN_LOW_SLOPE:  band_low   = data[BAND_W-1:0];
            CSR_TURN_HIGH_SLOPE: band_high  = data[BAND_W-1:0];
            CSR_ENTRY_TICKS:     enter_need = data[TICK_W-1:0];
            CSR_EXIT_TICKS:      leave_need = data[TICK_W-1:0];
            CSR_TURN_STEER:      turn_mag   = data[TSTEER_W-1:0];
            CSR_CENTER_GAIN:     gain       = data[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      // Vectoring arctangent of one slope, negated and brought to Q2.14.
      function logic signed [STEER_W-1:0] neg_atan(logic signed [SLOPE_W-1:0] slope);
         longint x, y, z, dx, dy, zm;
         x = longint'(1) << 24;
         y = longint'(slope) * 4096;
         z = 0;
         for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x = x + dx;
               y = y - dy;
               z = z + angle_q24[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - angle_q24[i];
            end
         end
         zm = (z < 0) ? -z : z;
         zm = (zm + 512) >>> 10;
         return STEER_W'((z < 0) ? zm : -zm);
      endfunction

      function void note_tick(tick_type t);
         logic signed [SUM_W-1:0] s2;
         logic [SUM_W-1:0]        mag;
         logic                    any_side;
         logic                    in_band;
         logic [THR_W-1:0]        half;
         longint                  err2;
         longint                  prod;
         command_type             c;
         c.steer    = '0;
         c.throttle = base_thr;
         if (t.left_valid && t.right_valid)
            s2 = t.slope_left + t.slope_right;
         else if (t.left_valid)
            s2 = t.slope_left + t.slope_left;
         else if (t.right_valid)
            s2 = t.slope_right + t.slope_right;
         else
            s2 = '0;
         mag      = s2[SUM_W-1] ? -s2 : s2;
         any_side = t.left_valid || t.right_valid;
         in_band  = (mag >= {band_low, 1'b0}) && (mag <= {band_high, 1'b0});

         if (!turn_mode) begin
            if (any_side && in_band) begin
               if (entry_count != '1)
                  entry_count = entry_count + 1'b1;
            end else begin
               entry_count = '0;
            end
            if (entry_count >= enter_need) begin
               turn_mode  = 1'b1;
               exit_count = '0;
               turn_left  = (s2 > 0) ? 1'b0 : 1'b1;
            end
         end

         if (turn_mode) begin
            half       = base_thr >> 1;
            c.steer    = turn_left ? $signed({1'b0, turn_mag}) : -$signed({1'b0, turn_mag});
            c.throttle = (half > min_thr) ? half : min_thr;
            if (any_side && !in_band) begin
               if (exit_count != '1)
                  exit_count = exit_count + 1'b1;
            end else begin
               exit_count = '0;
            end
            if (exit_count >= leave_need) begin
               turn_mode   = 1'b0;
               entry_count = '0;
            end
         end else if (t.left_valid && !t.right_valid) begin
            c.steer = neg_atan(t.slope_left);
         end else if (t.right_valid && !t.left_valid) begin
            c.steer = neg_atan(t.slope_right);
         end else if (t.left_valid && t.right_valid && t.center_valid) begin
            err2 = 2 * longint'(t.center_pos) - FRAME_COLS;
            prod = (longint'(gain) * ((err2 < 0) ? -err2 : err2) + 1024) >>> 11;
            prod = (err2 < 0) ? prod : -prod;
            if (prod > 32767)
               prod = 32767;
            else if (prod < -32768)
               prod = -32768;
            c.steer = STEER_W'(prod);
         end
         c.turning = turn_mode;
         pending_cmds.push_back(c);
      endfunction

      function void check_command(command_type got);
         command_type exp_cmd;
         if (pending_cmds.size() == 0) begin
            $display("%0t: command with none expected: steer %0d throttle %0d turning %0b",
                     $time, got.steer, got.throttle, got.turning);
            mismatches++;
            return;
         end
         exp_cmd = pending_cmds.pop_front();
         if (got.steer !== exp_cmd.steer) begin
            $display("%0t: steer expected %0d, got %0d", $time, exp_cmd.steer, got.steer);
            mismatches++;
         end
         if (got.throttle !== exp_cmd.throttle) begin
            $display("%0t: throttle expected %0d, got %0d",
                     $time, exp_cmd.throttle, got.throttle);
            mismatches++;
         end
         if (got.turning !== exp_cmd.turning) begin
            $display("%0t: turning expected %0b, got %0b",
                     $time, exp_cmd.turning, got.turning);
            mismatches++;
         end
      endfunction
   endclass

   logic           clock;
   logic           reset;
   bit             backlog_req;
   steer_book_type sb;
   command_type    seen_cmd;

   lktm_req_if req_if ();
   lktm_rsp_if rsp_if ();
   lktm_csr_if csr_if ();

   lane_keep_turn_mode_controller #(
      .FRAME_COLS(FRAME_COLS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   // 20 ns clock: high for half the period, low for the other half.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length between items and between accepted commands. Most pauses are
   // zero or short, and a few are long enough to let the pipeline run dry.
   function automatic int unsigned pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic tick_type mk(bit lv, bit rv, bit cv, int ls, int rs, int cp);
      tick_type t;
      t.left_valid   = lv;
      t.right_valid  = rv;
      t.center_valid = cv;
      t.slope_left   = SLOPE_W'(ls);
      t.slope_right  = SLOPE_W'(rs);
      t.center_pos   = CPOS_W'(cp);
      return t;
   endfunction

   // Builds one tick of the requested kind against the current slope band.
   // Noise ticks keep every flag and value random, no-slope ticks clear both sides,
   // and the band kinds place the tick slope deliberately inside or outside the band,
   // with the mean of both sides landing exactly on the chosen value when both are valid.
   function automatic tick_type make_tick(seg_kind_type kind);
      tick_type    t;
      int          lo, hi, mag, s, d, room;
      int unsigned sides;
      t.left_valid   = 1'($urandom_range(0, 1));
      t.right_valid  = 1'($urandom_range(0, 1));
      t.center_valid = 1'($urandom_range(0, 1));
      t.slope_left   = SLOPE_W'($urandom);
      t.slope_right  = SLOPE_W'($urandom);
      t.center_pos   = ($urandom_range(0, 3) != 0) ? CPOS_W'($urandom_range(0, FRAME_COLS - 1))
                                                   : CPOS_W'($urandom);
      lo = sb.band_low;
      hi = sb.band_high;
      if (kind == SEG_IN_BAND || kind == SEG_OUT_BAND) begin
         if (kind == SEG_IN_BAND)
            mag = $urandom_range(lo, hi);
         else if (lo > 0 && (hi >= SLOPE_MAX || $urandom_range(0, 1) == 1))
            mag = $urandom_range(0, lo - 1);
         else if (hi < SLOPE_MAX)
            mag = $urandom_range(hi + 1, SLOPE_MAX);
         else
            mag = $urandom_range(0, SLOPE_MAX);
         s     = ($urandom_range(0, 1) == 1) ? -mag : mag;
         sides = $urandom_range(0, 2);
         t.left_valid  = (sides != 1);
         t.right_valid = (sides != 0);
         if (sides == 2) begin
            room = SLOPE_MAX - mag;
            d    = $urandom_range(0, (room < 4000) ? room : 4000);
            if ($urandom_range(0, 1) == 1)
               d = -d;
            t.slope_left  = SLOPE_W'(s + d);
            t.slope_right = SLOPE_W'(s - d);
         end else if (sides == 0) begin
            t.slope_left = SLOPE_W'(s);
         end else begin
            t.slope_right = SLOPE_W'(s);
         end
      end else if (kind == SEG_NO_SLOPE) begin
         t.left_valid  = 1'b0;
         t.right_valid = 1'b0;
      end
      return t;
   endfunction

   // Offers one tick and holds it until the block takes it, then maybe idles.
   task automatic send_tick(tick_type t);
      int unsigned pause;
      req_if.left_valid   <= t.left_valid;
      req_if.right_valid  <= t.right_valid;
      req_if.center_valid <= t.center_valid;
      req_if.slope_left   <= t.slope_left;
      req_if.slope_right  <= t.slope_right;
      req_if.center_pos   <= t.center_pos;
      req_if.valid        <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      pause = pick_pause();
      if (pause != 0) begin
         req_if.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
   endtask

   // Stops offering ticks and waits until every predicted command has come
   // back. The first edge lets the monitor record the last accepted tick.
   task automatic drain(int unsigned settle);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_cmds.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register write; the data carries random bits above every field width.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_if.index <= idx;
      csr_if.data  <= value | ($urandom & 32'hFF00_0000);
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Rewrites every register once the block is idle, plus one write to an
   // index past the register file, which the block must ignore.
   task automatic apply_settings(int unsigned base_thr, int unsigned min_thr,
                                 int unsigned low, int unsigned high,
                                 int unsigned enter_need, int unsigned leave_need,
                                 int unsigned turn_mag, int unsigned gain);
      drain(4);
      write_reg(CSR_BASE_THROTTLE, base_thr);
      write_reg(CSR_MIN_THROTTLE, min_thr);
      write_reg(CSR_TURN_LOW_SLOPE, low);
      write_reg(CSR_TURN_HIGH_SLOPE, high);
      write_reg(CSR_ENTRY_TICKS, enter_need);
      write_reg(CSR_EXIT_TICKS, leave_need);
      write_reg(CSR_TURN_STEER, turn_mag);
      write_reg(CSR_CENTER_GAIN, gain);
      write_reg(CSR_INDEX_W'($urandom_range(NUM_REGS, 255)), $urandom);
   endtask

   // Typical settings: a narrow-to-moderate band and short hold counts, so
   // that turn mode is entered and left many times within one phase.
   task automatic random_settings();
      int unsigned low;
      low = $urandom_range(0, 2000);
      apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                     low, low + $urandom_range(0, 3000),
                     $urandom_range(0, 6), $urandom_range(0, 6),
                     $urandom_range(0, SLOPE_MAX),
                     ($urandom_range(0, 1) == 1) ? $urandom_range(0, 100000)
                                                 : ($urandom & 24'hFFFFFF));
   endtask

   // Random phase built from runs of ticks. In-band runs are sized around the
   // entry hold and out-of-band runs around the exit hold, so most runs carry
   // the block through a full entry or exit; short no-slope and noise runs
   // break the sequences. Optionally a long response hold-off is requested
   // one third in, and a full drain is done two thirds in.
   task automatic run_phase(int unsigned quota, bit with_backlog, bit with_drain);
      int unsigned  sent, run_len, cap, r;
      seg_kind_type kind;
      sent = 0;
      while (sent < quota) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            kind = SEG_IN_BAND;
            cap  = sb.enter_need + 3;
         end else if (r < 80) begin
            kind = SEG_OUT_BAND;
            cap  = sb.leave_need + 3;
         end else if (r < 90) begin
            kind = SEG_NO_SLOPE;
            cap  = 2;
         end else begin
            kind = SEG_NOISE;
            cap  = 3;
         end
         if (cap > 30)
            cap = 30;
         run_len = $urandom_range(1, cap);
         repeat (run_len) begin
            if (with_backlog && sent == quota / 3)
               backlog_req = 1'b1;
            if (with_drain && sent == 2 * quota / 3)
               drain(4);
            send_tick(make_tick(kind));
            sent++;
         end
      end
   endtask

   // Every handshake is observed here at the clock edge. Register writes
   // update the private register copy, accepted ticks produce a predicted
   // command, and accepted commands are checked against the oldest one.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            sb.write_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            sb.note_tick(mk(req_if.left_valid, req_if.right_valid, req_if.center_valid,
                            req_if.slope_left, req_if.slope_right, req_if.center_pos));
         if (rsp_if.valid && rsp_if.ready) begin
            seen_cmd.steer    = rsp_if.steer;
            seen_cmd.throttle = rsp_if.throttle;
            seen_cmd.turning  = rsp_if.turning;
            sb.check_command(seen_cmd);
         end
      end
   end

   // Response pacing. Ready alternates between runs of acceptance, some of
   // them long stretches with no stall, and stalls of random length. When
   // the stimulus asks for a backlog, ready stays low for a long counted
   // stretch so that the block fills up and pushes back on its input.
   initial begin : rsp_pacing
      int unsigned run_len, stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (backlog_req) begin
            backlog_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (BACKLOG_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 8);
         repeat (run_len) @(posedge clock);
         stall = pick_pause();
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Watchdog: the run is declared failed when no channel has moved an item
   // before the idle counter reaches IDLE_LIMIT.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      sb          = new();
      backlog_req = 1'b0;
      reset       <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.left_valid   <= 1'b0;
      req_if.right_valid  <= 1'b0;
      req_if.center_valid <= 1'b0;
      req_if.slope_left   <= '0;
      req_if.slope_right  <= '0;
      req_if.center_pos   <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset settings (band 410..1556, holds of 5).
      // A tick with no slope at all.
      send_tick(mk(0, 0, 1, 0, 0, 400));
      // One side alone at the slope extremes, and at zero and minus one.
      send_tick(mk(1, 0, 0, SLOPE_MAX, 0, 0));
      send_tick(mk(1, 0, 1, -32768, 0, 4095));
      send_tick(mk(0, 1, 0, 0, 0, 0));
      send_tick(mk(0, 1, 1, 0, -1, 0));
      // Both sides with the center at both ends, without the center, and
      // with the center exactly in the middle of the image.
      send_tick(mk(1, 1, 1, 100, -100, 0));
      send_tick(mk(1, 1, 1, 100, -100, 4095));
      send_tick(mk(1, 1, 0, 5, 7, 900));
      send_tick(mk(1, 1, 1, -3, 3, FRAME_COLS / 2));
      // Five in-band ticks: the low edge, the high edge, a mean right on
      // the low edge, a negative mean on the high edge, then a negative
      // slope that enters turn mode turning left.
      send_tick(mk(1, 0, 0, 410, 0, 0));
      send_tick(mk(0, 1, 0, 0, 1556, 0));
      send_tick(mk(1, 1, 1, 409, 411, 300));
      send_tick(mk(1, 1, 1, -1556, -1556, 300));
      send_tick(mk(1, 0, 1, -1000, 0, 300));
      // In turn mode: one tick just above the band, a tick with no slope
      // that clears the exit count, then five just below the band to leave.
      send_tick(mk(1, 0, 0, 1557, 0, 0));
      send_tick(mk(0, 0, 0, 0, 0, 0));
      repeat (5) send_tick(mk(0, 1, 0, 0, 409, 0));

      // Random phases, each under its own register settings.
      random_settings();
      run_phase(60, 1'b0, 1'b0);
      // Widest band, zero holds: entry and exit happen on the same tick.
      apply_settings(65535, 0, 0, SLOPE_MAX, 0, 0, SLOPE_MAX, 24'hFFFFFF);
      run_phase(60, 1'b0, 1'b0);
      // Maximum holds, a band of one value and zero gain and turn steer.
      apply_settings(0, 65535, SLOPE_MAX, SLOPE_MAX, 255, 255, 0, 0);
      run_phase(40, 1'b0, 1'b0);
      // Inverted band: nothing is in band, so turn mode is never entered.
      apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                     2000, 100, 1, 2, $urandom_range(0, SLOPE_MAX), 41943);
      run_phase(50, 1'b0, 1'b0);
      random_settings();
      run_phase(80, 1'b1, 1'b1);
      random_settings();
      run_phase(80, 1'b0, 1'b0);
      // Band starting at zero, so a zero slope can enter turn mode.
      apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                     0, $urandom_range(0, 2000), 1, 0,
                     $urandom_range(0, SLOPE_MAX), $urandom_range(0, 200000));
      run_phase(60, 1'b0, 1'b0);
      random_settings();
      run_phase(60, 1'b0, 1'b0);

      drain(40);
      if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
